// ----- hw/rtl/sitda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sitda_pkg;

  localparam int ValueW    = 32;
  localparam int DigitW    = 4;
  localparam int CharW     = 8;
  localparam int MaxDigits = 10;
  localparam int CntW      = 4;
  localparam int QDepth    = 2;
  localparam int QPtrW     = 1;
  localparam int QCntW     = 2;

  localparam logic [CharW-1:0]  AsciiZero  = 8'd48;
  localparam logic [CharW-1:0]  AsciiMinus = 8'd45;
  // floor(x * Recip10 / 2**Recip10Shift) equals x / 10 for every 32-bit x.
  localparam logic [ValueW-1:0] Recip10      = 32'hCCCC_CCCD;
  localparam int                Recip10Shift = 35;

  typedef logic [ValueW-1:0] mag_t;
  typedef logic [DigitW-1:0] digit_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [CntW-1:0]   cnt_t;

  typedef struct packed {
    logic neg;
    mag_t mag;
  } req_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sitda_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sitda_in_if import sitda_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t character;
  logic  last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sitda_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sitda_front import sitda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sitda_in_if.sink         in_chan,
  output      logic        push_valid,
  input  wire logic        push_ready,
  output      req_t        push_req
);

  logic front_valid_r, front_valid_nxt;
  req_t front_req_r, front_req_nxt;
  logic accept;
  mag_t raw;

  assign in_chan.ready = !front_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign raw           = mag_t'(in_chan.value);

  always_comb begin
    front_valid_nxt = front_valid_r;
    front_req_nxt   = front_req_r;
    if (accept) begin
      front_valid_nxt   = 1'b1;
      front_req_nxt.neg = raw[ValueW-1];
      // The magnitude is unsigned, so the most negative value stays exact.
      front_req_nxt.mag = raw[ValueW-1] ? (~raw + mag_t'(1)) : raw;
    end else if (push_ready) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_req_r <= front_req_nxt;
  end

  assign push_valid = front_valid_r;
  assign push_req   = front_req_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sitda_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sitda_queue import sitda_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output      logic push_ready,
  input  wire req_t push_req,
  output      logic pop_valid,
  input  wire logic pop_ready,
  output      req_t pop_req
);

  req_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != QCntW'(QDepth));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_req    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sitda_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sitda_back import sitda_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  output      logic pop_ready,
  input  wire req_t pop_req,
  sitda_out_if.source out_chan
);

  back_state_t state_r, state_nxt;
  mag_t        mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  cnt_t        cnt_r, cnt_nxt;
  digit_t      digit_r [MaxDigits];
  digit_t      digit_nxt [MaxDigits];
  logic        out_valid_r, out_valid_nxt;
  char_t       out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic [2*ValueW-1:0] prod;
  mag_t                quot;
  mag_t                quot_x10;
  digit_t              rem;
  logic                emit_ok;

  // One decimal digit per cycle: quotient by reciprocal, remainder by shift-add.
  assign prod     = {{ValueW{1'b0}}, mag_r} * {{ValueW{1'b0}}, Recip10};
  assign quot     = mag_t'(prod[2*ValueW-1:Recip10Shift]);
  assign quot_x10 = {quot[ValueW-4:0], 3'b000} + {quot[ValueW-2:0], 1'b0};
  assign rem      = digit_t'(mag_r - quot_x10);
  assign emit_ok  = !out_valid_r || out_chan.ready;

  assign pop_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (quot == '0) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (emit_ok && !neg_r && cnt_r == cnt_t'(1)) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    digit_nxt     = digit_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          mag_nxt = pop_req.mag;
          neg_nxt = pop_req.neg;
          cnt_nxt = '0;
        end
      end
      B_DIV: begin
        // Digits enter at the bottom, so the leading digit ends at index 0.
        mag_nxt      = quot;
        cnt_nxt      = cnt_r + cnt_t'(1);
        digit_nxt[0] = rem;
        for (int i = 1; i < MaxDigits; i++) begin
          digit_nxt[i] = digit_r[i-1];
        end
      end
      B_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = AsciiMinus;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = AsciiZero + char_t'(digit_r[0]);
            out_last_nxt = (cnt_r == cnt_t'(1));
            cnt_nxt      = cnt_r - cnt_t'(1);
            for (int i = 0; i < MaxDigits - 1; i++) begin
              digit_nxt[i] = digit_r[i+1];
            end
            digit_nxt[MaxDigits-1] = '0;
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digit_r    <= digit_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.character = out_char_r;
  assign out_chan.last      = out_last_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MaxDigits))
    else $error("digit count exceeds the digit store");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT) |-> (cnt_r != '0))
    else $error("emitting with no digits left");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT && emit_ok && !neg_r && cnt_r == cnt_t'(1))
      |=> (state_r == B_IDLE && out_valid_r && out_last_r))
    else $error("final digit did not end the run");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/signed_int_to_decimal_ascii_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Converts one signed 32-bit integer per request on in_chan into its decimal
// ASCII text on out_chan, one character per transfer, most significant digit
// first, with no leading zeros. A negative value starts with '-', and zero
// gives the single character '0'. The last character of each number has last
// set.
// A request passes the input register and a two-entry queue, then the digit
// unit takes it. The digit unit extracts one digit per cycle with a
// reciprocal multiply, then emits the characters, and takes the next
// request only once it is back in idle.
// Reset clears the input register, the queue, the digit unit and the output
// register. When the receiver stalls, the output register holds its
// character, the digit unit waits, and in_chan.ready drops once the queue
// and the input register are full.
module signed_int_to_decimal_ascii_core import sitda_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sitda_in_if.sink    in_chan,
  sitda_out_if.source out_chan
);

  logic push_valid, push_ready;
  req_t push_req;
  logic pop_valid, pop_ready;
  req_t pop_req;

  sitda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  sitda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  sitda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_req   (pop_req),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import sitda_pkg::*;

  typedef struct {
    logic signed [ValueW-1:0] value;
    int unsigned              gap;
    bit                       drain;
  } num_req_t;

  typedef struct {
    char_t character;
    logic  last;
  } char_rec_t;

  localparam int HoldAtItem  = 40;
  localparam int HoldCycles  = 300;
  localparam int SettleCycles = 50;

  logic clk;
  logic rst_n;

  sitda_in_if  in_chan ();
  sitda_out_if out_chan ();

  signed_int_to_decimal_ascii_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  num_req_t    pending[$];
  char_rec_t   chars_due[$];
  int          mismatches = 0;
  int          items_accepted = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int          hold_left = 0;
  bit          hold_started = 0;
  bit          sink_calm = 0;

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Appends the decimal text of num to the characters still due.
  function automatic void expect_text(input logic signed [ValueW-1:0] num);
    mag_t   rest;
    digit_t digs[MaxDigits];
    int     n;
    bit     minus;
    char_rec_t rec;
    minus = num[ValueW-1];
    rest  = num;
    if (minus) begin
      rest = ~rest + 1'b1;
    end
    if (rest == '0) begin
      rec.character = AsciiZero;
      rec.last      = 1'b1;
      chars_due.push_back(rec);
      return;
    end
    n = 0;
    while (rest != '0) begin
      digs[n] = digit_t'(rest % 10);
      rest    = rest / 10;
      n++;
    end
    if (minus) begin
      rec.character = AsciiMinus;
      rec.last      = 1'b0;
      chars_due.push_back(rec);
    end
    for (int i = n - 1; i >= 0; i--) begin
      rec.character = AsciiZero + char_t'(digs[i]);
      rec.last      = (i == 0);
      chars_due.push_back(rec);
    end
  endfunction

  function automatic void queue_num(input logic signed [ValueW-1:0] num,
                                    input int unsigned gap, input bit drain);
    num_req_t req;
    req.value = num;
    req.gap   = gap;
    req.drain = drain;
    pending.push_back(req);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic signed [ValueW-1:0] directed[$];
    mag_t pow10[10];
    logic signed [ValueW-1:0] num;
    int   idx;
    int unsigned gap;

    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    rst_n          = 1'b0;

    pow10[0] = 1;
    for (int i = 1; i < 10; i++) begin
      pow10[i] = pow10[i-1] * 10;
    end

    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 -32'sd100, 32'sd1000000000, 32'sd999999999, -32'sd999999999,
                 32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'sd2147483640, -32'sd1000000000, 32'sd7};
    foreach (directed[i]) begin
      queue_num(directed[i], rand_gap(), 1'b0);
    end

    for (int i = 0; i < 90; i++) begin
      idx = directed.size() + i;
      case ($urandom_range(0, 3))
        0: num = $urandom;
        1: num = $urandom_range(0, 999);
        2: num = $urandom >> $urandom_range(0, 31);
        default: num = pow10[$urandom_range(0, 9)] - $urandom_range(0, 1);
      endcase
      if (num >= 0 && $urandom_range(0, 1)) begin
        num = -num;
      end
      // A burst with no sender gaps lets the long receiver stall fill the block.
      gap = (idx >= 35 && idx <= 70) || idx >= 100 ? 0 : rand_gap();
      queue_num(num, gap, idx == 25 || idx == 90);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.value <= '0;
      src_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expect_text(in_chan.value);
        items_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && chars_due.size() != 0)) begin
          in_chan.valid <= 1'b1;
          in_chan.value <= pending[0].value;
          src_gap = pending[0].gap;
          void'(pending.pop_front());
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, including one long stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) begin
        sink_calm = !sink_calm;
      end
      if (!hold_started && items_accepted >= HoldAtItem) begin
        hold_started = 1'b1;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!sink_calm) begin
          snk_gap = rand_gap();
        end
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    char_rec_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (chars_due.size() == 0) begin
        $error("unexpected character: character %0d last %0b",
               out_chan.character, out_chan.last);
        mismatches++;
      end else begin
        want = chars_due.pop_front();
        if (out_chan.character !== want.character) begin
          $error("character mismatch: expected %0d actual %0d",
                 want.character, out_chan.character);
          mismatches++;
        end
        if (out_chan.last !== want.last) begin
          $error("last mismatch: expected %0b actual %0b", want.last, out_chan.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    while (pending.size() != 0 || in_chan.valid) @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && chars_due.size() == 0) begin
      $display("signed_int_to_decimal_ascii_core test passed");
    end else begin
      $display("signed_int_to_decimal_ascii_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("signed_int_to_decimal_ascii_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_if.sv
hw/rtl/sitda_front.sv
hw/rtl/sitda_queue.sv
hw/rtl/sitda_back.sv
hw/rtl/signed_int_to_decimal_ascii_core.sv
bench/tb_top.sv
